### hdl/fpl_pkg.sv
package fpl_pkg;

    localparam int Q_W = 32;
    localparam logic [Q_W-1:0] Q_ONE = 32'h8000_0000;
    localparam int ROW_ENTRIES = 32;
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT = DIV_STEPS + 1;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PATTERN = 1'b1;

    localparam logic [1:0] MODE_TIPS = 2'd0;
    localparam logic [1:0] MODE_MIXED = 2'd1;
    localparam logic [1:0] MODE_PARTIALS = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHILD_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_SCALING = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [1:0]  category;
        logic [4:0]  entry_index;
        logic [31:0] entry_value;
        logic [1:0]  left_state;
        logic [1:0]  right_state;
        logic [63:0] left_partials_low;
        logic [63:0] left_partials_high;
        logic [63:0] right_partials_low;
        logic [63:0] right_partials_high;
        logic [31:0] scale_factor;
        logic        last_pattern;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_partials_low;
        logic [63:0] out_partials_high;
        logic [1:0]  out_category;
        logic        out_last;
        logic        saturated;
    } t_out_item;

    typedef logic [ROW_ENTRIES-1:0][Q_W-1:0] t_row;
    typedef logic [3:0][Q_W-1:0] t_lanes;

    typedef struct packed {
        logic [1:0]     cat;
        logic           last;
        logic [1:0]     left_state;
        logic [1:0]     right_state;
        t_lanes         lp;
        t_lanes         rp;
        logic [Q_W-1:0] scale;
        t_row           row;
    } t_job;

    typedef struct packed {
        logic       valid;
        logic [1:0] cat;
        logic       last;
        logic       flag;
    } t_sb;

endpackage

### hdl/four_state_partial_likelihood.sv
// Throughput: one request per cycle while full is low, loads and patterns alike;
// the matrix memory delivers a whole category row per cycle and the divider is
// pipelined one bit per stage.
// Reset: synchronous, active low; clears valid state and sets child_mode 2, scaling off.
// Matrix memory contents are not cleared and must be loaded before use.
module four_state_partial_likelihood #(
    parameter int CATEGORIES = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  fpl_pkg::t_in_item                i_in_item,
    output logic                             empty,
    input  logic                             pop,
    output fpl_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_we,
    input  logic [fpl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fpl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [1:0]                  r_child_mode;
    logic                        r_fixed_scaling;
    logic                        w_accept;
    logic                        w_job_v;
    fpl_pkg::t_job               w_job;
    logic                        w_q_valid;
    fpl_pkg::t_job               w_q_data;
    logic [fpl_pkg::QCNT_W-1:0]  w_q_count;
    logic                        w_q_pop;
    logic                        w_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_child_mode    <= fpl_pkg::MODE_PARTIALS;
            r_fixed_scaling <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fpl_pkg::CFG_CHILD_MODE:    r_child_mode    <= i_cfg_data;
                fpl_pkg::CFG_FIXED_SCALING: r_fixed_scaling <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign full = ((fpl_pkg::QCNT_W+1)'(w_q_count) + (fpl_pkg::QCNT_W+1)'(w_job_v))
                  >= (fpl_pkg::QCNT_W+1)'(fpl_pkg::QDEPTH);
    assign w_accept = push && !full;

    fpl_front #(.CATEGORIES(CATEGORIES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_item),
        .o_job_valid (w_job_v),
        .o_job       (w_job)
    );

    fpl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_v),
        .i_data  (w_job),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    fpl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_child_mode),
        .i_scaling   (r_fixed_scaling),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_data),
        .o_job_pop   (w_q_pop),
        .i_pop       (pop),
        .o_out_valid (w_out_v),
        .o_out_item  (o_out_item)
    );

    assign empty = !w_out_v;

endmodule

### hdl/fpl_front.sv
module fpl_front #(
    parameter int CATEGORIES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  fpl_pkg::t_in_item i_item,
    output logic              o_job_valid,
    output fpl_pkg::t_job     o_job
);

    localparam int CAT_AW = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;

    fpl_pkg::t_row r_mem [CATEGORIES];
    fpl_pkg::t_job r_job;
    logic          r_job_v;
    logic          n_job_v;
    logic [1:0]    w_cat;
    logic [CAT_AW-1:0] w_addr;

    function automatic logic [1:0] f_reduce(input logic [1:0] c);
        logic [4:0] v;
        v = {3'b000, c};
        for (int k = 0; k < 3; k++) begin
            if (v >= 5'(CATEGORIES)) begin
                v = v - 5'(CATEGORIES);
            end
        end
        return v[1:0];
    endfunction

    assign w_cat   = f_reduce(i_item.category);
    assign w_addr  = CAT_AW'(w_cat);
    assign n_job_v = i_accept && (i_item.operation == fpl_pkg::OP_PATTERN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
        end else begin
            r_job_v <= n_job_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (i_item.operation == fpl_pkg::OP_LOAD) begin
                r_mem[w_addr][i_item.entry_index] <= i_item.entry_value;
            end else begin
                r_job.cat         <= w_cat;
                r_job.last        <= i_item.last_pattern;
                r_job.left_state  <= i_item.left_state;
                r_job.right_state <= i_item.right_state;
                r_job.lp          <= {i_item.left_partials_high, i_item.left_partials_low};
                r_job.rp          <= {i_item.right_partials_high, i_item.right_partials_low};
                r_job.scale       <= i_item.scale_factor;
                r_job.row         <= r_mem[w_addr];
            end
        end
    end

    assign o_job_valid = r_job_v;
    assign o_job       = r_job;

endmodule

### hdl/fpl_queue.sv
module fpl_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  fpl_pkg::t_job                i_data,
    input  logic                         i_pop,
    output logic                         o_valid,
    output fpl_pkg::t_job                o_data,
    output logic [fpl_pkg::QCNT_W-1:0]   o_count
);

    fpl_pkg::t_job                r_buf [fpl_pkg::QDEPTH];
    logic [fpl_pkg::QPTR_W-1:0]   r_wp;
    logic [fpl_pkg::QPTR_W-1:0]   r_rp;
    logic [fpl_pkg::QCNT_W-1:0]   r_cnt;
    logic                         w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + fpl_pkg::QCNT_W'(i_push) - fpl_pkg::QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rp];
    assign o_count = r_cnt;

endmodule

### hdl/fpl_div_lane.sv
module fpl_div_lane (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [fpl_pkg::Q_W-1:0] i_v,
    input  logic [fpl_pkg::Q_W-1:0] i_d,
    output logic [fpl_pkg::Q_W-1:0] o_v,
    output logic [fpl_pkg::Q_W-1:0] o_quo,
    output logic                    o_sat
);

    localparam int STEPS = fpl_pkg::DIV_STEPS;
    localparam int W = fpl_pkg::Q_W;

    logic [W-1:0] r_rem [STEPS+1];
    logic [W-1:0] r_quo [STEPS+1];
    logic [W-1:0] r_d   [STEPS+1];
    logic [W-1:0] r_v   [STEPS+1];
    logic         r_sat [STEPS+1];
    logic         r_b0;
    logic [W-1:0] n_rem [1:STEPS];
    logic [W-1:0] n_quo [1:STEPS];
    logic [W:0]   w_t   [1:STEPS];
    logic         w_ge  [1:STEPS];

    always_comb begin
        for (int k = 1; k <= STEPS; k++) begin
            w_t[k]   = {r_rem[k-1], (k == 1) ? r_b0 : 1'b0};
            w_ge[k]  = w_t[k] >= {1'b0, r_d[k-1]};
            n_rem[k] = w_ge[k] ? W'(w_t[k] - {1'b0, r_d[k-1]}) : w_t[k][W-1:0];
            n_quo[k] = {r_quo[k-1][W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= {1'b0, i_v} >= {i_d, 1'b0};
            r_rem[0] <= {1'b0, i_v[W-1:1]};
            r_quo[0] <= '0;
            r_d[0]   <= i_d;
            r_v[0]   <= i_v;
            r_b0     <= i_v[0];
            for (int k = 1; k <= STEPS; k++) begin
                r_sat[k] <= r_sat[k-1];
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_d[k]   <= r_d[k-1];
                r_v[k]   <= r_v[k-1];
            end
        end
    end

    assign o_sat = r_sat[STEPS] || (r_quo[STEPS] > fpl_pkg::Q_ONE);
    assign o_quo = o_sat ? fpl_pkg::Q_ONE : r_quo[STEPS];
    assign o_v   = r_v[STEPS];

endmodule

### hdl/fpl_back.sv
module fpl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_mode,
    input  logic               i_scaling,
    input  logic               i_job_valid,
    input  fpl_pkg::t_job      i_job,
    output logic               o_job_pop,
    input  logic               i_pop,
    output logic               o_out_valid,
    output fpl_pkg::t_out_item o_out_item
);

    localparam int W = fpl_pkg::Q_W;
    localparam int LAT = fpl_pkg::DIV_LAT;

    logic w_en;

    logic [1:0][3:0][3:0][W:0] n1_prod, r1_prod;
    logic [1:0][3:0][W-1:0]    n1_tip, r1_tip;
    fpl_pkg::t_sb              r1_sb;
    logic [W-1:0]              r1_scale;

    logic [1:0][3:0][W-1:0]    n2_side, r2_side;
    logic                      n2_flag;
    fpl_pkg::t_sb              r2_sb;
    logic [W-1:0]              r2_scale;

    logic [3:0][W-1:0]         n3_v, r3_v;
    fpl_pkg::t_sb              r3_sb;
    logic [W-1:0]              r3_scale;

    fpl_pkg::t_sb              r_sb [LAT];
    logic [3:0][W-1:0]         w_dv, w_dq, w_res;
    logic [3:0]                w_ds;
    logic                      w_flag;

    fpl_pkg::t_out_item        r_out, n_out;
    logic                      r_out_v;

    assign w_en      = !r_out_v || i_pop;
    assign o_job_pop = w_en && i_job_valid;

    always_comb begin
        fpl_pkg::t_lanes p;
        logic [1:0]      st;
        for (int s = 0; s < 2; s++) begin
            p  = (s == 0) ? i_job.lp : i_job.rp;
            st = (s == 0) ? i_job.left_state : i_job.right_state;
            for (int i = 0; i < 4; i++) begin
                n1_tip[s][i] = i_job.row[{1'(s), 2'(i), st}];
                for (int j = 0; j < 4; j++) begin
                    n1_prod[s][i][j] = (W+1)'((64'(i_job.row[{1'(s), 2'(i), 2'(j)}])
                                       * 64'(p[j])) >> 31);
                end
            end
        end
    end

    always_comb begin
        logic [W+2:0] x;
        logic         use_part;
        n2_flag = 1'b0;
        for (int s = 0; s < 2; s++) begin
            use_part = (s == 0) ? i_mode[1] : (i_mode != fpl_pkg::MODE_TIPS);
            for (int i = 0; i < 4; i++) begin
                x = use_part ? ((W+3)'(r1_prod[s][i][0]) + (W+3)'(r1_prod[s][i][1])
                              + (W+3)'(r1_prod[s][i][2]) + (W+3)'(r1_prod[s][i][3]))
                             : (W+3)'(r1_tip[s][i]);
                if (x > (W+3)'(fpl_pkg::Q_ONE)) begin
                    n2_side[s][i] = fpl_pkg::Q_ONE;
                    n2_flag = 1'b1;
                end else begin
                    n2_side[s][i] = x[W-1:0];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n3_v[i] = W'((64'(r2_side[0][i]) * 64'(r2_side[1][i])) >> 31);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_div
        fpl_div_lane u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_v   (r3_v[g]),
            .i_d   (r3_scale),
            .o_v   (w_dv[g]),
            .o_quo (w_dq[g]),
            .o_sat (w_ds[g])
        );
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_res[i] = i_scaling ? w_dq[i] : w_dv[i];
        end
        w_flag = r_sb[LAT-1].flag || (i_scaling && (w_ds != '0));
        n_out.out_partials_low  = {w_res[1], w_res[0]};
        n_out.out_partials_high = {w_res[3], w_res[2]};
        n_out.out_category      = r_sb[LAT-1].cat;
        n_out.out_last          = r_sb[LAT-1].last;
        n_out.saturated         = w_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_sb   <= '0;
            r2_sb   <= '0;
            r3_sb   <= '0;
            r_out_v <= 1'b0;
            for (int k = 0; k < LAT; k++) begin
                r_sb[k] <= '0;
            end
        end else if (w_en) begin
            r1_sb   <= '{valid: i_job_valid, cat: i_job.cat, last: i_job.last, flag: 1'b0};
            r2_sb   <= '{valid: r1_sb.valid, cat: r1_sb.cat, last: r1_sb.last, flag: n2_flag};
            r3_sb   <= r2_sb;
            r_sb[0] <= r3_sb;
            for (int k = 1; k < LAT; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
            r_out_v <= r_sb[LAT-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_prod  <= n1_prod;
            r1_tip   <= n1_tip;
            r1_scale <= i_job.scale;
            r2_side  <= n2_side;
            r2_scale <= r1_scale;
            r3_v     <= n3_v;
            r3_scale <= r2_scale;
            r_out    <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

### hdl/fpl_checker.sv
module fpl_checker #(
    parameter int CATEGORIES = 4
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input fpl_pkg::t_out_item o_out_item
);

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result present right after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed or vanished");

    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_out_item.out_partials_low[31:0] <= fpl_pkg::Q_ONE)
                 && (o_out_item.out_partials_low[63:32] <= fpl_pkg::Q_ONE)
                 && (o_out_item.out_partials_high[31:0] <= fpl_pkg::Q_ONE)
                 && (o_out_item.out_partials_high[63:32] <= fpl_pkg::Q_ONE)))
        else $error("result lane above 1.0");

    a_category_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (int'(o_out_item.out_category) < CATEGORIES))
        else $error("result category out of range");

endmodule

bind four_state_partial_likelihood fpl_checker #(.CATEGORIES(CATEGORIES)) u_fpl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);
